>>> rtl/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg
// Shared types, constants and codes of the page range allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 17;
    localparam int PAGES_W    = 20;
    localparam int PAGE_SHIFT = 12;
    localparam int CFG_IDX_W  = 2;

    // Default parameter values
    localparam int FREE_ENTRIES_DEF = 256;
    localparam int MAX_PAGES_DEF    = 65536;

    // Reset values of the heap registers (heap start already page aligned)
    localparam logic [ADDR_W-1:0] HEAP_END_RST = 32'hC080_0000;
    localparam logic [ADDR_W-1:0] BUMP_RST     = 32'h0010_0000;
    localparam logic [ADDR_W-1:0] PAGE_BYTES   = 32'h0000_1000;
    localparam logic [ADDR_W-1:0] PAGE_MASK    = 32'h0000_0FFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_END   = 2'd1;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_DROPPED   = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    // Operands of the shared unit: one add/subtract and one compare
    typedef struct packed {
        t_alu_op             op;
        logic [ADDR_W-1:0]   a;
        logic [ADDR_W-1:0]   b;
        logic [ADDR_W-1:0]   ca;
        logic [ADDR_W-1:0]   cb;
    } t_alu_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   y;
        logic                borrow;   // subtract: a < b
        logic                ge;       // ca >= cb
        logic                zero;     // y == 0
    } t_alu_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0]   start;
        logic [PAGES_W-1:0]  pages;
    } t_entry;

    typedef struct packed {
        logic                mode;
        logic [COUNT_W-1:0]  page_count;
        logic [ADDR_W-1:0]   address;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0]   base_address;
        t_status             status;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_START,
        S_A_RD,
        S_A_EVAL,
        S_A_FRD,
        S_A_FIT,
        S_A_TRIM,
        S_A_MOVE,
        S_A_BUMP,
        S_A_BCHK,
        S_F_START,
        S_F_RD,
        S_F_END,
        S_F_CHK,
        S_F_LO,
        S_F_HI,
        S_F_MOVE,
        S_F_APP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> rtl/pra_req_if.sv
// ----------------------------------------------------------------------------
// pra_req_if
// Request channel: mode, page count and address with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pra_req_if
    import pra_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [COUNT_W-1:0] page_count;
    logic [ADDR_W-1:0]  address;

    modport source (output valid, output mode, output page_count, output address,
                    input ready);
    modport sink   (input valid, input mode, input page_count, input address,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pra_rsp_if.sv
// ----------------------------------------------------------------------------
// pra_rsp_if
// Response channel: base address and status with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pra_rsp_if
    import pra_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] base_address;
    logic [1:0]        status;

    modport source (output valid, output base_address, output status, input ready);
    modport sink   (input valid, input base_address, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/pra_cfg_if.sv
// ----------------------------------------------------------------------------
// pra_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pra_cfg_if
    import pra_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pra_table.sv
// ----------------------------------------------------------------------------
// pra_table
// Free range table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_table
    import pra_pkg::*;
#(
    parameter int DEPTH = FREE_ENTRIES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire t_entry                   i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered: data follows in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/pra_alu.sv
// ----------------------------------------------------------------------------
// pra_alu
// Shared arithmetic unit: one 32-bit add/subtract and one unsigned compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_alu
    import pra_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [ADDR_W:0] sum;

    // Add or subtract with carry/borrow out
    always_comb begin
        unique case (i_req.op)
            ALU_ADD: sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: sum = '0;
        endcase
    end

    assign o_rsp.y      = sum[ADDR_W-1:0];
    assign o_rsp.borrow = sum[ADDR_W];
    assign o_rsp.ge     = (i_req.ca >= i_req.cb);
    assign o_rsp.zero   = (sum[ADDR_W-1:0] == '0);

endmodule

`default_nettype wire

>>> rtl/pra_seq.sv
// ----------------------------------------------------------------------------
// pra_seq
// Sequencer of the allocator: walks the free table entry by entry, drives
// the shared arithmetic unit and holds the bump pointer and heap limit.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_seq
    import pra_pkg::*;
#(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int MAX_PAGES    = MAX_PAGES_DEF,
    localparam int IDX_W       = $clog2(FREE_ENTRIES),
    localparam int CNT_W       = $clog2(FREE_ENTRIES + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request and configuration
    input  wire logic                 i_start,
    input  wire t_item                i_item,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    input  wire logic                 i_out_free,
    output logic                      o_idle,
    output logic                      o_done,
    output t_result                   o_result,
    // shared unit
    output t_alu_req                  o_alu,
    input  wire t_alu_rsp             i_alu,
    // table
    output logic                      o_tbl_we,
    output logic [IDX_W-1:0]          o_tbl_waddr,
    output t_entry                    o_tbl_wdata,
    output logic [IDX_W-1:0]          o_tbl_raddr,
    input  wire t_entry               i_tbl_rdata
);

    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_best, n_best;
    logic [PAGES_W-1:0]  r_best_pages, n_best_pages;
    logic                r_found, n_found;
    logic [ADDR_W-1:0]   r_lo, n_lo;
    logic [ADDR_W-1:0]   r_hi, n_hi;
    logic [ADDR_W-1:0]   r_s, n_s;
    logic [ADDR_W-1:0]   r_e, n_e;
    logic                r_hs, n_hs;
    logic [ADDR_W-1:0]   r_tmp, n_tmp;
    logic [ADDR_W-1:0]   r_bump, n_bump;
    logic [ADDR_W-1:0]   r_heap_end, n_heap_end;
    logic [ADDR_W-1:0]   r_base, n_base;
    t_status             r_status, n_status;

    logic [ADDR_W-1:0]   count32;
    logic [ADDR_W-1:0]   count_bytes;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    cnt_dec;
    logic                more;
    logic                take;

    assign count32     = {{(ADDR_W-COUNT_W){1'b0}}, r_count};
    assign count_bytes = {{(ADDR_W-COUNT_W-PAGE_SHIFT){1'b0}}, r_count,
                          {PAGE_SHIFT{1'b0}}};
    assign idx_inc     = CNT_W'(r_idx) + CNT_W'(1);
    assign cnt_dec     = r_cnt - CNT_W'(1);
    assign more        = (idx_inc < r_cnt);
    assign take        = i_alu.ge && (!r_found || i_alu.borrow);

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_bump     <= BUMP_RST;
            r_heap_end <= HEAP_END_RST;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_bump     <= n_bump;
            r_heap_end <= n_heap_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count      <= n_count;
        r_addr       <= n_addr;
        r_idx        <= n_idx;
        r_best       <= n_best;
        r_best_pages <= n_best_pages;
        r_found      <= n_found;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_s          <= n_s;
        r_e          <= n_e;
        r_hs         <= n_hs;
        r_tmp        <= n_tmp;
        r_base       <= n_base;
        r_status     <= n_status;
    end

    // Next state, datapath updates and unit/table controls
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_best       = r_best;
        n_best_pages = r_best_pages;
        n_found      = r_found;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_s          = r_s;
        n_e          = r_e;
        n_hs         = r_hs;
        n_tmp        = r_tmp;
        n_bump       = r_bump;
        n_heap_end   = r_heap_end;
        n_base       = r_base;
        n_status     = r_status;

        o_alu.op     = ALU_ADD;
        o_alu.a      = '0;
        o_alu.b      = '0;
        o_alu.ca     = '0;
        o_alu.cb     = '0;
        o_tbl_we     = 1'b0;
        o_tbl_waddr  = r_idx;
        o_tbl_wdata  = i_tbl_rdata;
        o_tbl_raddr  = r_idx;
        o_idle       = 1'b0;
        o_done       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_idle  = 1'b1;
                // config: round heap start up to a page
                o_alu.a = i_cfg_data;
                o_alu.b = PAGE_MASK;
                if (i_cfg_we) begin
                    if (i_cfg_idx == REG_HEAP_START) begin
                        n_bump = (i_alu.y[ADDR_W-1:PAGE_SHIFT] == '0) ? PAGE_BYTES
                               : {i_alu.y[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
                    end else if (i_cfg_idx == REG_HEAP_END) begin
                        n_heap_end = i_cfg_data;
                    end
                end
                if (i_start) begin
                    n_count = i_item.page_count;
                    n_addr  = i_item.address;
                    n_base  = '0;
                    n_state = (i_item.mode == MODE_FREE) ? S_F_START : S_A_START;
                end
            end

            // ---------------- allocate ----------------
            S_A_START: begin
                if (r_count == '0 || count32 > 32'(MAX_PAGES)) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else begin
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_state = (r_cnt == '0) ? S_A_BUMP : S_A_RD;
                end
            end

            S_A_RD: begin
                o_tbl_raddr = r_idx;
                n_state     = S_A_EVAL;
            end

            // fits if pages >= count; better if pages < best pages
            S_A_EVAL: begin
                o_alu.op = ALU_SUB;
                o_alu.a  = {{(ADDR_W-PAGES_W){1'b0}}, i_tbl_rdata.pages};
                o_alu.b  = {{(ADDR_W-PAGES_W){1'b0}}, r_best_pages};
                o_alu.ca = {{(ADDR_W-PAGES_W){1'b0}}, i_tbl_rdata.pages};
                o_alu.cb = count32;
                if (take) begin
                    n_best       = r_idx;
                    n_best_pages = i_tbl_rdata.pages;
                    n_found      = 1'b1;
                end
                if (more) begin
                    n_idx   = idx_inc[IDX_W-1:0];
                    n_state = S_A_RD;
                end else begin
                    n_state = (take || r_found) ? S_A_FRD : S_A_BUMP;
                end
            end

            S_A_FRD: begin
                o_tbl_raddr = r_best;
                n_state     = S_A_FIT;
            end

            // exact fit removes the entry, otherwise trim its front
            S_A_FIT: begin
                o_alu.op = ALU_SUB;
                o_alu.a  = {{(ADDR_W-PAGES_W){1'b0}}, i_tbl_rdata.pages};
                o_alu.b  = count32;
                n_base   = i_tbl_rdata.start;
                n_s      = i_tbl_rdata.start;
                n_tmp    = i_alu.y;
                if (i_alu.zero) begin
                    n_cnt       = cnt_dec;
                    o_tbl_raddr = cnt_dec[IDX_W-1:0];
                    n_state     = S_A_MOVE;
                end else begin
                    n_state = S_A_TRIM;
                end
            end

            S_A_TRIM: begin
                o_alu.a           = r_s;
                o_alu.b           = count_bytes;
                o_tbl_we          = 1'b1;
                o_tbl_waddr       = r_best;
                o_tbl_wdata.start = i_alu.y;
                o_tbl_wdata.pages = r_tmp[PAGES_W-1:0];
                n_status          = ST_OK;
                n_state           = S_DONE;
            end

            S_A_MOVE: begin
                o_tbl_we    = 1'b1;
                o_tbl_waddr = r_best;
                o_tbl_wdata = i_tbl_rdata;
                n_status    = ST_OK;
                n_state     = S_DONE;
            end

            // bump pointer must not be above the heap end
            S_A_BUMP: begin
                o_alu.op = ALU_SUB;
                o_alu.a  = r_heap_end;
                o_alu.b  = r_bump;
                o_alu.ca = r_heap_end;
                o_alu.cb = r_bump;
                n_tmp    = i_alu.y;
                if (i_alu.ge) begin
                    n_state = S_A_BCHK;
                end else begin
                    n_status = ST_EXHAUSTED;
                    n_state  = S_DONE;
                end
            end

            // room left in whole pages must cover the request
            S_A_BCHK: begin
                o_alu.a  = r_bump;
                o_alu.b  = count_bytes;
                o_alu.ca = {{PAGE_SHIFT{1'b0}}, r_tmp[ADDR_W-1:PAGE_SHIFT]};
                o_alu.cb = count32;
                if (i_alu.ge) begin
                    n_base   = r_bump;
                    n_bump   = i_alu.y;
                    n_status = ST_OK;
                end else begin
                    n_status = ST_EXHAUSTED;
                end
                n_state = S_DONE;
            end

            // ---------------- free ----------------
            S_F_START: begin
                o_alu.a = r_addr;
                o_alu.b = count_bytes;
                if ((r_addr & PAGE_MASK) != '0) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else if (r_count == '0) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_lo    = r_addr;
                    n_hi    = i_alu.y;
                    n_idx   = '0;
                    n_state = (r_cnt == '0) ? S_F_APP : S_F_RD;
                end
            end

            S_F_RD: begin
                o_tbl_raddr = r_idx;
                n_state     = S_F_END;
            end

            // entry end address, and start <= hi
            S_F_END: begin
                o_alu.a  = i_tbl_rdata.start;
                o_alu.b  = {i_tbl_rdata.pages, {PAGE_SHIFT{1'b0}}};
                o_alu.ca = r_hi;
                o_alu.cb = i_tbl_rdata.start;
                n_s      = i_tbl_rdata.start;
                n_e      = i_alu.y;
                n_hs     = i_alu.ge;
                n_state  = S_F_CHK;
            end

            // end >= lo completes the overlap/touch test
            S_F_CHK: begin
                o_alu.ca = r_e;
                o_alu.cb = r_lo;
                if (i_alu.ge && r_hs) begin
                    n_state = S_F_LO;
                end else if (more) begin
                    n_idx   = idx_inc[IDX_W-1:0];
                    n_state = S_F_RD;
                end else begin
                    n_state = S_F_APP;
                end
            end

            S_F_LO: begin
                o_alu.ca = r_s;
                o_alu.cb = r_lo;
                if (!i_alu.ge) begin
                    n_lo = r_s;
                end
                n_state = S_F_HI;
            end

            // widen hi, then drop the entry by moving the last one in
            S_F_HI: begin
                o_alu.ca = r_hi;
                o_alu.cb = r_e;
                if (!i_alu.ge) begin
                    n_hi = r_e;
                end
                n_cnt       = cnt_dec;
                o_tbl_raddr = cnt_dec[IDX_W-1:0];
                n_state     = S_F_MOVE;
            end

            // rescan from the first entry after a merge
            S_F_MOVE: begin
                o_tbl_we    = 1'b1;
                o_tbl_waddr = r_idx;
                o_tbl_wdata = i_tbl_rdata;
                n_idx       = '0;
                n_state     = (r_cnt == '0) ? S_F_APP : S_F_RD;
            end

            S_F_APP: begin
                o_alu.op = ALU_SUB;
                o_alu.a  = r_hi;
                o_alu.b  = r_lo;
                if (r_cnt >= CNT_W'(FREE_ENTRIES)) begin
                    n_status = ST_DROPPED;
                end else begin
                    o_tbl_we          = 1'b1;
                    o_tbl_waddr       = r_cnt[IDX_W-1:0];
                    o_tbl_wdata.start = r_lo;
                    o_tbl_wdata.pages = i_alu.y[ADDR_W-1:PAGE_SHIFT];
                    n_cnt             = r_cnt + CNT_W'(1);
                    n_status          = ST_OK;
                end
                n_state = S_DONE;
            end

            // hand result to the output register
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result.base_address = r_base;
    assign o_result.status       = r_status;

endmodule

`default_nettype wire

>>> rtl/page_range_allocator.sv
// ----------------------------------------------------------------------------
// page_range_allocator
// Best-fit page range allocator with a coalescing free table and a bump
// pointer, built around one shared add/compare unit under a sequencer.
//
//  channel   dir  handshake        payload
//  i_req     in   valid / ready    mode, page_count, address
//  o_rsp     out  valid / ready    base_address, status
//  i_cfg     in   valid / ready    index, data (0 heap_start, 1 heap_end)
//
//  Allocate: a best-fit scan reads each table entry, then trims or
//  removes the best one, else uses the bump pointer. Free: each merge
//  moves the last entry in and restarts the scan, so the worst case
//  grows with the square of the entry count (single table read port).
//  Reset is synchronous; the table needs no clearing. i_req is ready
//  only while idle; a finished result waits in the output register
//  while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module page_range_allocator
    import pra_pkg::*;
#(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int MAX_PAGES    = MAX_PAGES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pra_req_if.sink    i_req,
    pra_rsp_if.source  o_rsp,
    pra_cfg_if.sink    i_cfg
);

    localparam int IDX_W = $clog2(FREE_ENTRIES);

    logic              seq_idle;
    logic              seq_done;
    logic              out_free;
    logic              req_take;
    t_item             item;
    t_result           seq_result;
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr;
    t_entry            tbl_wdata;
    logic [IDX_W-1:0]  tbl_raddr;
    t_entry            tbl_rdata;

    logic              r_out_valid;
    t_result           r_out;

    // Handshakes: a config write wins over a request in the same cycle
    assign i_cfg.ready = seq_idle;
    assign i_req.ready = seq_idle && !i_cfg.valid;
    assign req_take    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign item.mode       = i_req.mode;
    assign item.page_count = i_req.page_count;
    assign item.address    = i_req.address;

    pra_seq #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .MAX_PAGES    (MAX_PAGES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (req_take),
        .i_item      (item),
        .i_cfg_we    (i_cfg.valid && i_cfg.ready),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_free  (out_free),
        .o_idle      (seq_idle),
        .o_done      (seq_done),
        .o_result    (seq_result),
        .o_alu       (alu_req),
        .i_alu       (alu_rsp),
        .o_tbl_we    (tbl_we),
        .o_tbl_waddr (tbl_waddr),
        .o_tbl_wdata (tbl_wdata),
        .o_tbl_raddr (tbl_raddr),
        .i_tbl_rdata (tbl_rdata)
    );

    pra_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    pra_table #(
        .DEPTH (FREE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_out <= seq_result;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.base_address = r_out.base_address;
    assign o_rsp.status       = r_out.status;

    // Assertions
    a_no_cfg_with_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.valid && i_req.ready && i_cfg.valid && i_cfg.ready))
        else $error("config write and request taken in the same cycle");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request ready right after a transaction");

    a_done_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |-> (!r_out_valid || o_rsp.ready))
        else $error("result overwrote a pending response");

    a_rsp_follows_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |=> o_rsp.valid)
        else $error("finished result not presented");

endmodule

`default_nettype wire
